@@ src/oss_pkg.sv @@
package oss_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned KEY_W    = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [KEY_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] query_value;
    logic                    hit;
    logic                    full_res;
  } rsp_t;

endpackage

@@ src/order_statistic_set.sv @@
// Channel   Direction  Handshake                       Payload
// request   in         start_i high while busy_o low   req_i  (mode, operand)
// result    out        done_o strobe, 1 cycle          rsp_o  (query_value, hit, full_res)
//
// A query reads the key of rank k; a k out of range or an unused mode is answered
// with no RAM read. Insert and delete run a binary search in the key RAM (s probes,
// at most ceil(log2(count+1))); a duplicate insert, an absent delete or a dropped
// insert ends there, else m keys are shifted one per cycle through the single write
// port. Reset clears the key count and the control state, not the key RAM.
// The result cannot be stalled; the next request is taken in its result cycle.
module order_statistic_set (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  oss_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output oss_pkg::rsp_t rsp_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRCH = 3'd1;  // issue binary-search read
  localparam logic [2:0] ST_CMP  = 3'd2;  // narrow the search window
  localparam logic [2:0] ST_INS  = 3'd3;  // shift keys up, then store new key
  localparam logic [2:0] ST_DEL  = 3'd4;  // shift keys down over removed one
  localparam logic [2:0] ST_QRD  = 3'd5;  // rank read returns

  localparam int unsigned CNT_W = oss_pkg::CNT_W;
  localparam int unsigned IDX_W = oss_pkg::IDX_W;
  localparam int unsigned KEY_W = oss_pkg::KEY_W;

  // key RAM: one write port, one read port, registered read data
  logic signed [KEY_W-1:0] mem [oss_pkg::CAPACITY];
  logic signed [KEY_W-1:0] rdata_q;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_wa, mem_ra;
  logic signed [KEY_W-1:0] mem_wd;

  logic [2:0]              state_q, state_d;
  logic [1:0]              mode_q, mode_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W-1:0]        mid_q, mid_d;
  logic                    eq_q, eq_d;
  logic [CNT_W-1:0]        j_q, j_d, pos_q, pos_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        wa_q, wa_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    done_q, done_d;
  oss_pkg::rsp_t           rsp_q, rsp_d;

  logic [CNT_W:0]          sum;
  logic [CNT_W-1:0]        mid_full;
  logic                    rank_ok;
  logic [KEY_W-1:0]        rank_m1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_full = sum[CNT_W:1];
  // k in 1..count
  assign rank_ok  = !req_i.operand[KEY_W-1] && (req_i.operand != '0) &&
                    (req_i.operand[KEY_W-2:0] <= (KEY_W-1)'(count_q));
  assign rank_m1  = req_i.operand - KEY_W'(1);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    key_d   = key_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    eq_d    = eq_q;
    j_d     = j_q;
    pos_d   = pos_q;
    pend_d  = pend_q;
    wa_d    = wa_q;
    count_d = count_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    mem_we  = 1'b0;
    mem_wa  = wa_q;
    mem_wd  = rdata_q;
    mem_re  = 1'b0;
    mem_ra  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mode_d = req_i.mode;
          key_d  = req_i.operand;
          lo_d   = '0;
          hi_d   = count_q;
          eq_d   = 1'b0;
          unique case (req_i.mode)
            oss_pkg::MODE_INSERT, oss_pkg::MODE_DELETE: begin
              state_d = ST_SRCH;
            end
            oss_pkg::MODE_QUERY: begin
              if (rank_ok) begin
                mem_re  = 1'b1;
                mem_ra  = rank_m1[IDX_W-1:0];
                state_d = ST_QRD;
              end else begin
                done_d = 1'b1;
                rsp_d  = '0;
              end
            end
            default: begin
              // unused mode: no change, all-zero result
              done_d = 1'b1;
              rsp_d  = '0;
            end
          endcase
        end
      end

      ST_SRCH: begin
        if (lo_q < hi_q) begin
          mem_re  = 1'b1;
          mem_ra  = mid_full[IDX_W-1:0];
          mid_d   = mid_full;
          state_d = ST_CMP;
        end else if (eq_q) begin
          // key present at lo_q
          if (mode_q == oss_pkg::MODE_INSERT) begin
            done_d  = 1'b1;
            rsp_d   = '{query_value: '0, hit: 1'b1, full_res: 1'b0};
            state_d = ST_IDLE;
          end else begin
            j_d     = lo_q + CNT_W'(1);
            pend_d  = 1'b0;
            state_d = ST_DEL;
          end
        end else if (mode_q == oss_pkg::MODE_DELETE) begin
          done_d  = 1'b1;
          rsp_d   = '0;
          state_d = ST_IDLE;
        end else if (count_q == CNT_W'(oss_pkg::CAPACITY)) begin
          done_d  = 1'b1;
          rsp_d   = '{query_value: '0, hit: 1'b0, full_res: 1'b1};
          state_d = ST_IDLE;
        end else begin
          j_d     = count_q;
          pos_d   = lo_q;
          pend_d  = 1'b0;
          state_d = ST_INS;
        end
      end

      ST_CMP: begin
        // hi only moves onto an entry >= key; equality there means found
        if (rdata_q < key_q) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
          eq_d = (rdata_q == key_q);
        end
        state_d = ST_SRCH;
      end

      ST_INS: begin
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = wa_q;
          mem_wd = rdata_q;
        end
        if (j_q > pos_q) begin
          // move entry j-1 to j
          mem_re = 1'b1;
          mem_ra = IDX_W'(j_q - CNT_W'(1));
          wa_d   = j_q[IDX_W-1:0];
          j_d    = j_q - CNT_W'(1);
          pend_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          mem_we  = 1'b1;
          mem_wa  = pos_q[IDX_W-1:0];
          mem_wd  = key_q;
          count_d = count_q + CNT_W'(1);
          done_d  = 1'b1;
          rsp_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_DEL: begin
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = wa_q;
          mem_wd = rdata_q;
        end
        if (j_q < count_q) begin
          // move entry j to j-1
          mem_re = 1'b1;
          mem_ra = j_q[IDX_W-1:0];
          wa_d   = IDX_W'(j_q - CNT_W'(1));
          j_d    = j_q + CNT_W'(1);
          pend_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          count_d = count_q - CNT_W'(1);
          done_d  = 1'b1;
          rsp_d   = '{query_value: '0, hit: 1'b1, full_res: 1'b0};
          state_d = ST_IDLE;
        end
      end

      ST_QRD: begin
        done_d  = 1'b1;
        rsp_d   = '{query_value: rdata_q, hit: 1'b1, full_res: 1'b0};
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    key_q  <= key_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    eq_q   <= eq_d;
    j_q    <= j_d;
    pos_q  <= pos_d;
    wa_q   <= wa_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
